// ===== rtl/svlr_pkg.sv =====
// Package for the supply voltage lock regulator.
// Holds command codes, register indexes, widths, reset values and the step and state bundle types.
// No dependencies.
`timescale 1ns / 1ps

package svlr_pkg;

    // Regulator code width and its largest value
    localparam int CODE_BITS = 8;
    localparam logic [CODE_BITS-1:0] CODE_MAX = {CODE_BITS{1'b1}};
    localparam logic [CODE_BITS-1:0] CODE_RESET = CODE_BITS'(8'hFF);

    // Field and register widths
    localparam int CMD_BITS    = 2;
    localparam int MV_BITS     = 16;
    localparam int LEN_BITS    = 8;
    localparam int GAIN_BITS   = 20;
    localparam int IDLE_BITS   = 8;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 20;

    // Fixed-point step: product, rounding and integer part
    localparam int FRAC_BITS  = 16;
    localparam int PROD_BITS  = MV_BITS + GAIN_BITS;
    localparam int ROUND_BITS = PROD_BITS + 1;
    localparam int STEP_FULL_BITS = ROUND_BITS - FRAC_BITS;
    localparam logic [ROUND_BITS-1:0] ROUND_HALF = ROUND_BITS'(1) << (FRAC_BITS - 1);

    // Commands
    localparam logic [CMD_BITS-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_START  = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_STOP   = 2'd2;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_TARGET    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_TOLERANCE = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOCK_LEN  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_GAIN      = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_IDLE      = 3'd4;

    // Register reset values
    localparam logic [MV_BITS-1:0]   TARGET_RESET    = 16'd0;
    localparam logic [MV_BITS-1:0]   TOLERANCE_RESET = 16'd100;
    localparam logic [LEN_BITS-1:0]  LOCK_LEN_RESET  = 8'd10;
    localparam logic [GAIN_BITS-1:0] GAIN_RESET      = 20'd6554;
    localparam logic [IDLE_BITS-1:0] IDLE_RESET      = 8'd255;

    // Prepared step for the state stage
    typedef struct packed {
        logic                 valid;
        logic [CMD_BITS-1:0]  command;
        logic                 low;
        logic                 in_tol;
        logic [CODE_BITS-1:0] step;
    } t_step;

    // Regulator state as seen on the result side
    typedef struct packed {
        logic [CODE_BITS-1:0] code;
        logic                 feedback_on;
        logic                 is_locked;
        logic                 lock_event;
    } t_state;

endpackage

// ===== rtl/svlr_in_if.sv =====
// Input channel of the supply voltage lock regulator: command and sample.
// Depends on svlr_pkg.
`timescale 1ns / 1ps

interface svlr_in_if;
    import svlr_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_BITS-1:0] command;
    logic [MV_BITS-1:0]  measured_mv;

    modport source (output valid, output command, output measured_mv, input ready);
    modport sink   (input valid, input command, input measured_mv, output ready);
endinterface

// ===== rtl/svlr_out_if.sv =====
// Result channel of the supply voltage lock regulator.
// Depends on svlr_pkg.
`timescale 1ns / 1ps

interface svlr_out_if;
    import svlr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CODE_BITS-1:0] regulator_code;
    logic                 feedback_on;
    logic                 is_locked;
    logic                 lock_event;

    modport source (output valid, output regulator_code, output feedback_on,
                    output is_locked, output lock_event, input ready);
    modport sink   (input valid, input regulator_code, input feedback_on,
                    input is_locked, input lock_event, output ready);
endinterface

// ===== rtl/svlr_step.sv =====
// Front stages: absolute error and tolerance test, then gain multiply,
// rounding and step saturation. Depends on svlr_pkg.
`timescale 1ns / 1ps

module svlr_step (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [svlr_pkg::CMD_BITS-1:0]  i_command,
    input  logic [svlr_pkg::MV_BITS-1:0]   i_measured_mv,
    input  logic [svlr_pkg::MV_BITS-1:0]   i_target_mv,
    input  logic [svlr_pkg::MV_BITS-1:0]   i_tolerance_mv,
    input  logic [svlr_pkg::GAIN_BITS-1:0] i_gain_q16,
    output svlr_pkg::t_step                o_step
);
    import svlr_pkg::*;

    logic                r_a_valid;
    logic [CMD_BITS-1:0] r_a_command;
    logic                r_a_low;
    logic                r_a_in_tol;
    logic [MV_BITS-1:0]  r_a_err;

    logic                n_low;
    logic [MV_BITS-1:0]  n_err;

    logic [PROD_BITS-1:0]      w_prod;
    logic [ROUND_BITS-1:0]     w_round;
    logic [STEP_FULL_BITS-1:0] w_step_full;
    logic [CODE_BITS-1:0]      n_step;

    t_step r_step;

    // Absolute error against the target
    always_comb begin
        n_low = i_measured_mv < i_target_mv;
        n_err = n_low ? (i_target_mv - i_measured_mv) : (i_measured_mv - i_target_mv);
    end

    // Advance the input stage valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_valid;
        end
    end

    // Capture the item with its error
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_command <= i_command;
            r_a_low     <= n_low;
            r_a_in_tol  <= n_err <= i_tolerance_mv;
            r_a_err     <= n_err;
        end
    end

    // Multiply by the gain, round half up, force at least 1, cap at the code range
    always_comb begin
        w_prod      = PROD_BITS'(r_a_err) * PROD_BITS'(i_gain_q16);
        w_round     = ROUND_BITS'(w_prod) + ROUND_HALF;
        w_step_full = w_round[ROUND_BITS-1:FRAC_BITS];
        if (w_step_full == '0) begin
            n_step = CODE_BITS'(1);
        end else if (w_step_full > STEP_FULL_BITS'(CODE_MAX)) begin
            n_step = CODE_MAX;
        end else begin
            n_step = w_step_full[CODE_BITS-1:0];
        end
    end

    // Hold the prepared step and its valid flag for the state stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step.valid <= 1'b0;
        end else if (i_en) begin
            r_step.valid <= r_a_valid;
        end
        if (i_en) begin
            r_step.command <= r_a_command;
            r_step.low     <= r_a_low;
            r_step.in_tol  <= r_a_in_tol;
            r_step.step    <= n_step;
        end
    end

    assign o_step = r_step;

endmodule

// ===== rtl/svlr_core.sv =====
// State stage: feedback flag, lock count, regulator code and lock flag.
// Its registers double as the result register. Depends on svlr_pkg.
`timescale 1ns / 1ps

module svlr_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  svlr_pkg::t_step                i_step,
    input  logic [svlr_pkg::LEN_BITS-1:0]  i_lock_length,
    input  logic [svlr_pkg::IDLE_BITS-1:0] i_idle_code,
    output svlr_pkg::t_state               o_state
);
    import svlr_pkg::*;

    logic                 r_feedback;
    logic [LEN_BITS-1:0]  r_count;
    logic [CODE_BITS-1:0] r_code;
    logic                 r_locked;
    logic                 r_event;

    logic                 n_feedback;
    logic [LEN_BITS-1:0]  n_count;
    logic [CODE_BITS-1:0] n_code;
    logic                 n_locked;
    logic                 n_event;

    logic [CODE_BITS:0]   w_sum;
    logic [CODE_BITS-1:0] w_idle;

    assign w_idle = CODE_BITS'(i_idle_code);
    assign w_sum  = {1'b0, r_code} + {1'b0, i_step.step};

    // Next state for the item in the state stage
    always_comb begin
        n_feedback = r_feedback;
        n_count    = r_count;
        n_code     = r_code;
        n_locked   = r_locked;
        n_event    = 1'b0;
        case (i_step.command)
            CMD_START: begin
                n_code     = w_idle;
                n_count    = '0;
                n_feedback = 1'b1;
                n_locked   = 1'b0;
            end
            CMD_STOP: begin
                n_feedback = 1'b0;
                n_locked   = 1'b0;
                n_code     = w_idle;
            end
            CMD_SAMPLE: begin
                if (r_feedback) begin
                    if (i_step.in_tol) begin
                        if (r_count < i_lock_length) begin
                            n_count = r_count + LEN_BITS'(1);
                        end else begin
                            n_feedback = 1'b0;
                            n_locked   = 1'b1;
                            n_event    = 1'b1;
                        end
                    end else begin
                        n_count = '0;
                        if (i_step.low) begin
                            n_code = (i_step.step > r_code) ? '0 : (r_code - i_step.step);
                        end else begin
                            n_code = w_sum[CODE_BITS] ? CODE_MAX : w_sum[CODE_BITS-1:0];
                        end
                    end
                end
            end
            default: begin
                // unused command: state holds
            end
        endcase
    end

    // Update state when an item leaves the front stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feedback <= 1'b0;
            r_count    <= '0;
            r_code     <= CODE_RESET;
            r_locked   <= 1'b0;
            r_event    <= 1'b0;
        end else if (i_en && i_step.valid) begin
            r_feedback <= n_feedback;
            r_count    <= n_count;
            r_code     <= n_code;
            r_locked   <= n_locked;
            r_event    <= n_event;
        end
    end

    assign o_state.code        = r_code;
    assign o_state.feedback_on = r_feedback;
    assign o_state.is_locked   = r_locked;
    assign o_state.lock_event  = r_event;

endmodule

// ===== rtl/supply_voltage_lock_regulator_unit.sv =====
// Top level of the supply voltage lock regulator: configuration registers,
// pipeline flow control and result channel. Depends on svlr_pkg, svlr_in_if,
// svlr_out_if, svlr_step and svlr_core.
//
//   Channel  Dir  Handshake        Payload
//   i_in     in   valid / ready    command, measured_mv
//   o_out    out  valid / ready    regulator_code, feedback_on, is_locked, lock_event
//   i_cfg_*  in   i_cfg_wr_en      i_cfg_idx, i_cfg_data
//
// One item per cycle sustained; each item passes from accept to result through
// the error register, step register (gain multiply) and state register.
// The whole pipeline advances when the result register is empty or taken, so
// a stalled result holds every stage and drops ready on the input.
// Reset is synchronous and active low; it restores register defaults and the
// idle state with code 255.
`timescale 1ns / 1ps

module supply_voltage_lock_regulator_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    svlr_in_if.sink                            i_in,
    svlr_out_if.source                         o_out,
    input  logic                               i_cfg_wr_en,
    input  logic [svlr_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [svlr_pkg::CFG_DATA_BITS-1:0] i_cfg_data
);
    import svlr_pkg::*;

    logic [MV_BITS-1:0]   r_target_mv;
    logic [MV_BITS-1:0]   r_tolerance_mv;
    logic [LEN_BITS-1:0]  r_lock_length;
    logic [GAIN_BITS-1:0] r_gain_q16;
    logic [IDLE_BITS-1:0] r_idle_code;

    logic   r_out_valid;
    logic   w_en;
    t_step  w_step;
    t_state w_state;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_mv    <= TARGET_RESET;
            r_tolerance_mv <= TOLERANCE_RESET;
            r_lock_length  <= LOCK_LEN_RESET;
            r_gain_q16     <= GAIN_RESET;
            r_idle_code    <= IDLE_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_idx)
                REG_TARGET:    r_target_mv    <= i_cfg_data[MV_BITS-1:0];
                REG_TOLERANCE: r_tolerance_mv <= i_cfg_data[MV_BITS-1:0];
                REG_LOCK_LEN:  r_lock_length  <= i_cfg_data[LEN_BITS-1:0];
                REG_GAIN:      r_gain_q16     <= i_cfg_data[GAIN_BITS-1:0];
                REG_IDLE:      r_idle_code    <= i_cfg_data[IDLE_BITS-1:0];
                default: begin
                    // write beyond the register list is dropped
                end
            endcase
        end
    end

    // Advance the pipeline when the result register is free
    assign w_en       = !r_out_valid || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_step.valid;
        end
    end

    svlr_step u_step (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (i_in.valid),
        .i_command      (i_in.command),
        .i_measured_mv  (i_in.measured_mv),
        .i_target_mv    (r_target_mv),
        .i_tolerance_mv (r_tolerance_mv),
        .i_gain_q16     (r_gain_q16),
        .o_step         (w_step)
    );

    svlr_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_step        (w_step),
        .i_lock_length (r_lock_length),
        .i_idle_code   (r_idle_code),
        .o_state       (w_state)
    );

    // Drive the result channel from the state registers
    assign o_out.valid          = r_out_valid;
    assign o_out.regulator_code = w_state.code;
    assign o_out.feedback_on    = w_state.feedback_on;
    assign o_out.is_locked      = w_state.is_locked;
    assign o_out.lock_event     = w_state.lock_event;

    // Lock and feedback never stand together
    a_lock_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_state.is_locked |-> !w_state.feedback_on)
        else $error("lock flag set while feedback is active");

    // A lock event carries the lock flag
    a_event_locked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.lock_event) |-> o_out.is_locked)
        else $error("lock event without lock flag");

    // A stalled result keeps the regulator state
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> ($stable(w_state) && o_out.valid))
        else $error("regulator state changed while result stalled");

    // Ready follows the result side alone
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_out.valid) |-> i_in.ready)
        else $error("input stalled with an empty result register");

endmodule
